/* rtl/assert_macros.svh */
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MLFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be true outside reset
`define MLFS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* rtl/mlfs_pkg.sv */
// shared constants and types for the multilevel feedback scheduler
package mlfs_pkg;

  // default sizes
  localparam int MLFS_LEVELS  = 8;
  localparam int MLFS_THREADS = 16;

  // fixed field widths
  localparam int MODE_W  = 3;
  localparam int TID_W   = 4;
  localparam int LEVEL_W = 3;

  // event kinds
  localparam logic [MODE_W-1:0] MODE_NEW     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_END     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TIMER   = 3'd4;

  // request from the sequencer to the queue pointer bank
  typedef struct packed {
    logic push;
    logic pop;
  } ptr_op_t;

  // status of the selected level
  typedef struct packed {
    logic full;
    logic nonempty;
  } ptr_sts_t;

endpackage

/* rtl/mlfs_ifs.sv */
// event and result channel interfaces
interface mlfs_evt_if import mlfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TID_W-1:0]  thread_id;

  modport source (output valid, mode, thread_id, input ready);
  modport sink   (input valid, mode, thread_id, output ready);
endinterface

interface mlfs_res_if import mlfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               switched;
  logic [TID_W-1:0]   old_thread;
  logic [TID_W-1:0]   new_thread;
  logic               none_ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, switched, old_thread, new_thread, none_ready, level,
                  input ready);
  modport sink   (input valid, switched, old_thread, new_thread, none_ready, level,
                  output ready);
endinterface

/* rtl/mlfs_queue_store.sv */
// thread number storage for all ready fifos, one write and one read port
module mlfs_queue_store import mlfs_pkg::*; #(
  parameter int LEVELS  = MLFS_LEVELS,
  parameter int THREADS = MLFS_THREADS
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [$clog2(LEVELS)+$clog2(THREADS)-1:0]     waddr_i,
  input  logic [TID_W-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [$clog2(LEVELS)+$clog2(THREADS)-1:0]     raddr_i,
  output logic [TID_W-1:0]                              rdata_o
);

  localparam int ADDR_W = $clog2(LEVELS) + $clog2(THREADS);
  localparam int DEPTH  = LEVELS * (2 ** $clog2(THREADS));

  logic [TID_W-1:0] mem_q [DEPTH];
  logic [TID_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mlfs_queue_ptrs.sv */
// head, tail and fill count of every ready fifo, one level served at a time
module mlfs_queue_ptrs import mlfs_pkg::*; #(
  parameter int LEVELS  = MLFS_LEVELS,
  parameter int THREADS = MLFS_THREADS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ptr_op_t                     op_i,
  input  logic [$clog2(LEVELS)-1:0]   lvl_i,
  output ptr_sts_t                    sts_o,
  output logic [$clog2(THREADS)-1:0]  head_o,
  output logic [$clog2(THREADS)-1:0]  tail_o
);

  localparam int PTR_W  = $clog2(THREADS);
  localparam int FILL_W = $clog2(THREADS + 1);

  logic [PTR_W-1:0]  head_q [LEVELS];
  logic [PTR_W-1:0]  tail_q [LEVELS];
  logic [FILL_W-1:0] fill_q [LEVELS];

  logic [PTR_W-1:0]  head_sel;
  logic [PTR_W-1:0]  tail_sel;
  logic [FILL_W-1:0] fill_sel;
  logic              full_sel;
  logic              do_push;
  logic              do_pop;

  // selected level
  assign head_sel = head_q[lvl_i];
  assign tail_sel = tail_q[lvl_i];
  assign fill_sel = fill_q[lvl_i];
  assign full_sel = (fill_sel == FILL_W'(THREADS));

  assign do_push = op_i.push && !full_sel;
  assign do_pop  = op_i.pop && (fill_sel != '0);

  assign sts_o.full     = full_sel;
  assign sts_o.nonempty = (fill_sel != '0);
  assign head_o         = head_sel;
  assign tail_o         = tail_sel;

  // pointer and count update, wrapping at the fifo depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (do_push) begin
        tail_q[lvl_i] <= (tail_sel == PTR_W'(THREADS - 1)) ? '0 : tail_sel + 1'b1;
        fill_q[lvl_i] <= fill_sel + 1'b1;
      end else if (do_pop) begin
        head_q[lvl_i] <= (head_sel == PTR_W'(THREADS - 1)) ? '0 : head_sel + 1'b1;
        fill_q[lvl_i] <= fill_sel - 1'b1;
      end
    end
  end

endmodule

/* rtl/multilevel_feedback_scheduler_unit.sv */
// multilevel feedback scheduler: event sequencer, ready fifos and result register
//
// Usage: each word on evt_i names an event kind (new, block, end, unblock,
// timer tick) and a thread. Exactly one result word per event leaves on
// res_o: whether a switch was decided, the old and new thread, whether no
// thread was ready, and the current priority level afterwards.
// An event is worked on by a small sequencer around one level counter and
// one compare: an optional fifo push, then, for a switching event, a scan
// of the levels from 0 upwards, one level per cycle, and a registered
// memory read of the chosen fifo head. evt_i.ready is low while the event
// is in work. Reset empties all fifos, clears the running thread, the
// level and the thread count; the fifo storage itself is not cleared and
// needs no pass. A result waits in its output register while res_o.ready
// is low; the next event is accepted meanwhile and its result is held
// back until the register is free.
`include "assert_macros.svh"

module multilevel_feedback_scheduler_unit import mlfs_pkg::*; #(
  parameter int LEVELS  = MLFS_LEVELS,
  parameter int THREADS = MLFS_THREADS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlfs_evt_if.sink    evt_i,
  mlfs_res_if.source  res_o
);

  localparam int LVL_W = $clog2(LEVELS);
  localparam int PTR_W = $clog2(THREADS);
  localparam int TOT_W = $clog2(THREADS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_POP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [TID_W-1:0] push_tid_q, push_tid_d;
  logic             sw_q, sw_d;
  logic [TID_W-1:0] running_q, running_d;
  logic [LVL_W-1:0] cur_lvl_q, cur_lvl_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [TID_W-1:0] old_q, old_d;
  logic [TID_W-1:0] new_q, new_d;
  logic             none_q, none_d;

  logic               out_valid_q, out_valid_d;
  logic               out_sw_q, out_sw_d;
  logic [TID_W-1:0]   out_old_q, out_old_d;
  logic [TID_W-1:0]   out_new_q, out_new_d;
  logic               out_none_q, out_none_d;
  logic [LEVEL_W-1:0] out_lvl_q, out_lvl_d;

  ptr_op_t          ptr_op;
  ptr_sts_t         ptr_sts;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic             mem_we;
  logic             mem_re;
  logic [TID_W-1:0] mem_rdata;

  logic             accept;
  logic             tid_ok;
  logic             ev_push;
  logic             ev_sw;
  logic             demote;
  logic             last_lvl;

  // queue pointer bank and storage
  mlfs_queue_ptrs #(
    .LEVELS  (LEVELS),
    .THREADS (THREADS)
  ) u_ptrs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (ptr_op),
    .lvl_i  (lvl_q),
    .sts_o  (ptr_sts),
    .head_o (head),
    .tail_o (tail)
  );

  mlfs_queue_store #(
    .LEVELS  (LEVELS),
    .THREADS (THREADS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({lvl_q, tail}),
    .wdata_i (push_tid_q),
    .re_i    (mem_re),
    .raddr_i ({lvl_q, head}),
    .rdata_o (mem_rdata)
  );

  // event decode
  assign evt_i.ready = (state_q == S_IDLE);
  assign accept      = evt_i.valid && evt_i.ready;
  assign tid_ok      = (evt_i.mode == MODE_TIMER) || (32'(evt_i.thread_id) < THREADS);
  assign last_lvl    = (lvl_q == LVL_W'(LEVELS - 1));
  assign demote      = (cur_lvl_q != LVL_W'(LEVELS - 1)) && (total_q > TOT_W'(1));

  always_comb begin
    ev_push = 1'b0;
    ev_sw   = 1'b0;
    case (evt_i.mode)
      MODE_NEW, MODE_UNBLOCK: ev_push = tid_ok;
      MODE_BLOCK, MODE_END:   ev_sw   = tid_ok;
      MODE_TIMER: begin
        ev_push = 1'b1;
        ev_sw   = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    push_tid_d  = push_tid_q;
    sw_d        = sw_q;
    running_d   = running_q;
    cur_lvl_d   = cur_lvl_q;
    total_d     = total_q;
    old_d       = old_q;
    new_d       = new_q;
    none_d      = none_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_sw_d    = out_sw_q;
    out_old_d   = out_old_q;
    out_new_d   = out_new_q;
    out_none_d  = out_none_q;
    out_lvl_d   = out_lvl_q;
    ptr_op      = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sw_d   = ev_sw;
          old_d  = ev_sw ? running_q : '0;
          new_d  = ev_sw ? running_q : '0;
          none_d = ev_sw;
          if (evt_i.mode == MODE_TIMER) begin
            push_tid_d = running_q;
            lvl_d      = cur_lvl_q + LVL_W'(demote);
          end else begin
            push_tid_d = evt_i.thread_id;
            lvl_d      = '0;
          end
          // new thread: level back to 0, count up with saturation
          if (evt_i.mode == MODE_NEW && tid_ok) begin
            cur_lvl_d = '0;
            if (total_q != TOT_W'(THREADS)) begin
              total_d = total_q + 1'b1;
            end
          end
          if (ev_push) begin
            state_d = S_PUSH;
          end else if (ev_sw) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PUSH: begin
        ptr_op.push = 1'b1;
        mem_we      = !ptr_sts.full;
        lvl_d       = '0;
        state_d     = sw_q ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (ptr_sts.nonempty) begin
          ptr_op.pop = 1'b1;
          mem_re     = 1'b1;
          state_d    = S_POP;
        end else if (last_lvl) begin
          state_d = S_DONE;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      S_POP: begin
        running_d = mem_rdata;
        cur_lvl_d = lvl_q;
        new_d     = mem_rdata;
        none_d    = 1'b0;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_sw_d    = sw_q;
          out_old_d   = old_q;
          out_new_d   = new_q;
          out_none_d  = none_q;
          out_lvl_d   = LEVEL_W'(cur_lvl_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= '0;
      cur_lvl_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
      sw_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      cur_lvl_q   <= cur_lvl_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      lvl_q       <= lvl_d;
      sw_q        <= sw_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    push_tid_q <= push_tid_d;
    old_q      <= old_d;
    new_q      <= new_d;
    none_q     <= none_d;
    out_sw_q   <= out_sw_d;
    out_old_q  <= out_old_d;
    out_new_q  <= out_new_d;
    out_none_q <= out_none_d;
    out_lvl_q  <= out_lvl_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.switched   = out_sw_q;
  assign res_o.old_thread = out_old_q;
  assign res_o.new_thread = out_new_q;
  assign res_o.none_ready = out_none_q;
  assign res_o.level      = out_lvl_q;

  // checks
  `MLFS_ASSERT(a_idle_keeps_thread,
               (res_o.valid && res_o.none_ready) |-> (res_o.new_thread == res_o.old_thread),
               "nothing ready but running thread changed")
  `MLFS_ASSERT(a_no_switch_zero,
               (res_o.valid && !res_o.switched) |->
                 (res_o.old_thread == '0 && res_o.new_thread == '0),
               "thread numbers reported without a switch")
  `MLFS_NEVER(a_none_needs_switch,
              res_o.valid && res_o.none_ready && !res_o.switched,
              "idle flag without a switch")
  `MLFS_ASSERT(a_level_range,
               cur_lvl_q <= LVL_W'(LEVELS - 1),
               "current level beyond the last level")

endmodule
